// ===== rtl/lpd_pkg.sv =====
// Shared types and constants for the length-prefix deframer.
`default_nettype none

package lpd_pkg;

    // Width of the maximum-length register and of the payload byte counter.
    localparam int MAX_LEN_W = 17;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 17'h10000;

    // Default number of length header bytes.
    localparam int LPD_HEADER_BYTES = 4;

    // Depth of the queue between classification and output.
    localparam int LPD_QUEUE_DEPTH = 2;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       last_in_message;
    } lpd_result_t;

endpackage

`default_nettype wire

// ===== rtl/lpd_front.sv =====
// Front part: takes stream bytes, collects the length header and classifies each byte.
`default_nettype none

module lpd_front
    import lpd_pkg::*;
#(
    parameter int HEADER_BYTES = LPD_HEADER_BYTES
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 stream_valid,
    input  wire logic [7:0]           stream_byte,
    output logic                      stream_stall,
    input  wire logic                 max_length_we,
    input  wire logic [MAX_LEN_W-1:0] max_length_wdata,
    input  wire logic                 q_full,
    output logic                      q_push,
    output lpd_result_t               q_push_data
);

    localparam int HDR_W = 8 * HEADER_BYTES;
    localparam int CNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int CMP_W = (HDR_W > MAX_LEN_W) ? HDR_W : MAX_LEN_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(HEADER_BYTES - 1);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HALTED  = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [CNT_W-1:0]     hdr_count_reg, hdr_count_next;
    logic [HDR_W-1:0]     hdr_shift_reg, hdr_shift_next;
    logic [MAX_LEN_W-1:0] remaining_reg, remaining_next;
    logic [MAX_LEN_W-1:0] max_length_reg;

    logic             accept;
    logic             take_hdr;
    logic             hdr_done;
    logic [HDR_W-1:0] hdr_raw;
    logic [CMP_W-1:0] raw_ext;
    logic [CMP_W-1:0] max_ext;
    logic             negative;
    logic             too_long;
    logic             is_zero;

    assign stream_stall = q_full;
    assign accept       = stream_valid && !q_full;

    // The header value including the byte arriving now.
    assign hdr_raw  = HDR_W'({hdr_shift_reg, stream_byte});
    assign hdr_done = (hdr_count_reg == LAST_CNT);
    assign negative = hdr_raw[HDR_W-1];
    assign raw_ext  = CMP_W'(hdr_raw);
    assign max_ext  = CMP_W'(max_length_reg);
    assign too_long = (raw_ext > max_ext);
    assign is_zero  = (hdr_raw == '0);

    // A payload phase with no bytes left falls back to header collection.
    assign take_hdr = (phase_reg == PH_HEADER) ||
                      ((phase_reg == PH_PAYLOAD) && (remaining_reg == '0));

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        hdr_shift_next = hdr_shift_reg;
        remaining_next = remaining_reg;
        q_push         = 1'b0;
        q_push_data    = '{kind: KIND_BYTE, payload_byte: 8'd0, last_in_message: 1'b0};

        if (accept)
        begin
            case (phase_reg)
                PH_HEADER, PH_PAYLOAD:
                begin
                    if (take_hdr)
                    begin
                        phase_next     = PH_HEADER;
                        hdr_shift_next = hdr_raw;
                        hdr_count_next = CNT_W'(hdr_count_reg + 1'b1);
                        if (hdr_done)
                        begin
                            hdr_count_next = '0;
                            hdr_shift_next = '0;
                            if (negative || too_long)
                            begin
                                phase_next       = PH_HALTED;
                                q_push           = 1'b1;
                                q_push_data.kind = KIND_ERROR;
                            end
                            else if (is_zero)
                            begin
                                q_push                      = 1'b1;
                                q_push_data.kind            = KIND_EMPTY;
                                q_push_data.last_in_message = 1'b1;
                            end
                            else
                            begin
                                remaining_next = MAX_LEN_W'(raw_ext);
                                phase_next     = PH_PAYLOAD;
                            end
                        end
                    end
                    else
                    begin
                        remaining_next           = remaining_reg - 1'b1;
                        q_push                   = 1'b1;
                        q_push_data.kind         = KIND_BYTE;
                        q_push_data.payload_byte = stream_byte;
                        if (remaining_reg == MAX_LEN_W'(1))
                        begin
                            q_push_data.last_in_message = 1'b1;
                            phase_next                  = PH_HEADER;
                        end
                    end
                end
                default:
                begin
                    // Halted: bytes are dropped until reset.
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            hdr_count_reg  <= '0;
            hdr_shift_reg  <= '0;
            remaining_reg  <= '0;
            max_length_reg <= MAX_LEN_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            hdr_shift_reg <= hdr_shift_next;
            remaining_reg <= remaining_next;
            if (max_length_we)
            begin
                max_length_reg <= max_length_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lpd_queue.sv =====
// Short result queue between the front and back parts.
`default_nettype none

module lpd_queue
    import lpd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire lpd_result_t  push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output lpd_result_t       pop_data
);

    localparam int PTR_W = (LPD_QUEUE_DEPTH > 1) ? $clog2(LPD_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(LPD_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(LPD_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LPD_QUEUE_DEPTH);

    lpd_result_t      entry_reg [LPD_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lpd_back.sv =====
// Back part: output register that presents queued results on the result channel.
`default_nettype none

module lpd_back
    import lpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_not_empty,
    input  wire lpd_result_t q_data,
    output logic             q_pop,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic             last_in_message
);

    logic        out_valid_reg, out_valid_next;
    lpd_result_t out_data_reg;
    logic        load;

    // The register refills from a non-empty queue whenever it is empty or its transaction completes now.
    assign load  = q_not_empty && (!out_valid_reg || !result_stall);
    assign q_pop = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= q_data;
        end
    end

    assign result_valid    = out_valid_reg;
    assign kind            = out_data_reg.kind;
    assign payload_byte    = out_data_reg.payload_byte;
    assign last_in_message = out_data_reg.last_in_message;

endmodule

`default_nettype wire

// ===== rtl/length_prefix_deframer.sv =====
// Top level of the length-prefix deframer.
//
//   Channel   Handshake                  Payload
//   stream    stream_valid/stream_stall  stream_byte
//   result    result_valid/result_stall  kind, payload_byte, last_in_message
//   config    max_length_we              max_length_wdata
//
// One stream byte is accepted every clock while stream_stall is low; the front state machine handles a byte per cycle.
// A result passes through the result queue and then the output register before it appears on result_valid.
// Reset is asynchronous and active low; max_length returns to 65536 and header collection
// restarts. stream_stall rises only when the two-entry result queue is full, which happens
// while result_stall holds results back.
`default_nettype none

module length_prefix_deframer
    import lpd_pkg::*;
#(
    parameter int HEADER_BYTES = LPD_HEADER_BYTES
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 stream_valid,
    output logic                      stream_stall,
    input  wire logic [7:0]           stream_byte,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [1:0]                kind,
    output logic [7:0]                payload_byte,
    output logic                      last_in_message,
    input  wire logic                 max_length_we,
    input  wire logic [MAX_LEN_W-1:0] max_length_wdata
);

    logic        q_full;
    logic        q_push;
    lpd_result_t q_push_data;
    logic        q_pop;
    logic        q_not_empty;
    lpd_result_t q_pop_data;

    lpd_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .stream_valid     (stream_valid),
        .stream_byte      (stream_byte),
        .stream_stall     (stream_stall),
        .max_length_we    (max_length_we),
        .max_length_wdata (max_length_wdata),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_push_data      (q_push_data)
    );

    lpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    lpd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_data          (q_pop_data),
        .q_pop           (q_pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .kind            (kind),
        .payload_byte    (payload_byte),
        .last_in_message (last_in_message)
    );

endmodule

`default_nettype wire

// ===== rtl/lpd_checker.sv =====
// Port-level assertions for the length-prefix deframer, bound to the top level.
`default_nettype none

module lpd_checker
    import lpd_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 result_valid,
    input wire logic                 result_stall,
    input wire logic [1:0]           kind,
    input wire logic [7:0]           payload_byte,
    input wire logic                 last_in_message
);

    logic error_seen_reg;

    // Remembers that an error transaction has gone out since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_seen_reg <= 1'b0;
        end
        else if (result_valid && !result_stall && (kind == KIND_ERROR))
        begin
            error_seen_reg <= 1'b1;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(kind) &&
            $stable(payload_byte) && $stable(last_in_message))
        else $error("result changed while stalled");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_ERROR) |-> (payload_byte == 8'd0) && !last_in_message)
        else $error("error result carries data or end mark");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_EMPTY) |-> (payload_byte == 8'd0) && last_in_message)
        else $error("empty message result malformed");

    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        error_seen_reg |-> !result_valid)
        else $error("result after an invalid length error");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (.*);

`default_nettype wire

// ===== tb/tb_length_prefix_deframer.sv =====
// Self-checking testbench for the length-prefix deframer.
`timescale 1ns / 100ps

module tb_length_prefix_deframer
    import lpd_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 6;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int NUM_PHASES = 5;

    typedef enum logic [1:0] {ST_HEADER, ST_PAYLOAD, ST_HALTED} deframe_state_t;
    typedef enum int {MIX_NONE, MIX_SENDER, MIX_RECEIVER, MIX_BOTH} idle_mix_t;

    // One stream byte, with its expected outcome when that is typed in by hand.
    typedef struct packed {
        logic [7:0]  b;
        logic        typed;
        logic        has;
        lpd_result_t r;
    } stim_row_t;

    localparam lpd_result_t NO_RESULT = '0;

    localparam stim_row_t LEAD_ROWS [22] = '{
        // Zero length gives one empty message.
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1, '{KIND_EMPTY, 8'h00, 1'b1}},
        // A single byte is both first and last.
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'h01, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, '{KIND_BYTE, 8'hFF, 1'b1}},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1, '{KIND_BYTE, 8'h00, 1'b0}},
        '{8'hA5, 1'b1, 1'b1, '{KIND_BYTE, 8'hA5, 1'b1}},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h03, 1'b0, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, 1'b0, NO_RESULT}
    };

    localparam logic [MAX_LEN_W-1:0] PHASE_LIMITS [NUM_PHASES] =
        '{17'h1FFFF, 17'd0, 17'd1, 17'd37, 17'h10000};
    localparam idle_mix_t PHASE_MIXES [NUM_PHASES] =
        '{MIX_SENDER, MIX_RECEIVER, MIX_BOTH, MIX_NONE, MIX_RECEIVER};

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 stream_valid = 1'b0;
    logic                 stream_stall;
    logic [7:0]           stream_byte = 8'h00;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [1:0]           kind;
    logic [7:0]           payload_byte;
    logic                 last_in_message;
    logic                 max_length_we = 1'b0;
    logic [MAX_LEN_W-1:0] max_length_wdata = '0;

    length_prefix_deframer uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .stream_valid     (stream_valid),
        .stream_stall     (stream_stall),
        .stream_byte      (stream_byte),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .kind             (kind),
        .payload_byte     (payload_byte),
        .last_in_message  (last_in_message),
        .max_length_we    (max_length_we),
        .max_length_wdata (max_length_wdata)
    );

    // Predictor state, a copy of what the deframer holds.
    deframe_state_t       dfr_state = ST_HEADER;
    int                   hdr_count = 0;
    logic [31:0]          hdr_shift = '0;
    logic [MAX_LEN_W-1:0] left_bytes = '0;
    logic [MAX_LEN_W-1:0] len_limit = MAX_LEN_RESET;

    stim_row_t   stim_notes[$];
    lpd_result_t pending_results[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int accepted_bytes = 0;
    int items_sent = 0;
    int mismatches = 0;
    int cycles = 0;
    int payload_seen = 0;
    int empty_seen = 0;
    int error_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic bit deframe_step(input logic [7:0] b, output lpd_result_t res);
        logic [31:0] len;
        res = '0;
        if (dfr_state == ST_HALTED)
            return 1'b0;
        if (dfr_state == ST_PAYLOAD && left_bytes != 0)
        begin
            left_bytes = left_bytes - 1'b1;
            res.kind = KIND_BYTE;
            res.payload_byte = b;
            res.last_in_message = (left_bytes == 0);
            if (left_bytes == 0)
                dfr_state = ST_HEADER;
            return 1'b1;
        end
        dfr_state = ST_HEADER;
        hdr_shift = {hdr_shift[23:0], b};
        hdr_count++;
        if (hdr_count < LPD_HEADER_BYTES)
            return 1'b0;
        len = hdr_shift;
        hdr_count = 0;
        hdr_shift = '0;
        // The header is a signed 32-bit count, so a set top bit is a negative length.
        if (len[31] || len > 32'(len_limit))
        begin
            dfr_state = ST_HALTED;
            res.kind = KIND_ERROR;
            return 1'b1;
        end
        if (len == 0)
        begin
            res.kind = KIND_EMPTY;
            res.last_in_message = 1'b1;
            return 1'b1;
        end
        left_bytes = len[MAX_LEN_W-1:0];
        dfr_state = ST_PAYLOAD;
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        stim_row_t   note;
        lpd_result_t want;
        lpd_result_t got;
        bit          produced;
        if (rst_n)
        begin
            if (max_length_we)
                len_limit = max_length_wdata;
            if (stream_valid && !stream_stall)
            begin
                note = stim_notes.pop_front();
                produced = deframe_step(stream_byte, want);
                if (note.typed)
                begin
                    produced = note.has;
                    want = note.r;
                end
                if (produced)
                    pending_results.push_back(want);
                accepted_bytes++;
            end
            if (result_valid && !result_stall)
            begin
                got = '{kind, payload_byte, last_in_message};
                case (got.kind)
                    KIND_BYTE:  payload_seen++;
                    KIND_EMPTY: empty_seen++;
                    default:    error_seen++;
                endcase
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d, payload_byte 0x%02h, last %0b",
                           got.kind, got.payload_byte, got.last_in_message);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        mismatches++;
                    end
                    if (got.payload_byte !== want.payload_byte)
                    begin
                        $error("payload_byte: expected 0x%02h, got 0x%02h",
                               want.payload_byte, got.payload_byte);
                        mismatches++;
                    end
                    if (got.last_in_message !== want.last_in_message)
                    begin
                        $error("last_in_message: expected %0b, got %0b",
                               want.last_in_message, got.last_in_message);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < stall_pct);

    function automatic stim_row_t plain(input logic [7:0] b);
        stim_row_t row;
        row = '0;
        row.b = b;
        return row;
    endfunction

    task automatic put_byte(input stim_row_t row);
        int seen;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            stream_valid <= 1'b0;
            @(negedge clk);
        end
        stream_valid <= 1'b1;
        stream_byte <= row.b;
        stim_notes.push_back(row);
        items_sent++;
        seen = accepted_bytes;
        do
            @(negedge clk);
        while (accepted_bytes == seen);
    endtask

    task automatic drain_results();
        stream_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_frame(input int unsigned len);
        for (int i = LPD_HEADER_BYTES - 1; i >= 0; i--)
            put_byte(plain(8'(len >> (8 * i))));
        for (int unsigned j = 0; j < len; j++)
            put_byte(plain(8'($urandom_range(0, 255))));
    endtask

    function automatic int unsigned pick_length(input logic [MAX_LEN_W-1:0] lim);
        int unsigned cap;
        int unsigned roll;
        cap = (lim < 24) ? 32'(lim) : 24;
        roll = $urandom_range(0, 99);
        if (roll < 8 && lim <= 64)
            return 32'(lim);
        if (roll < 15)
            return 0;
        if (roll < 18 && lim >= 600)
            return $urandom_range(100, 600);
        return $urandom_range(0, cap);
    endfunction

    task automatic run_frames(input logic [MAX_LEN_W-1:0] lim);
        int start;
        start = items_sent;
        while (items_sent - start < ITEMS_PER_PHASE)
        begin
            // Now and then hold the stream until the output side has caught up.
            if ($urandom_range(0, 9) == 0)
                drain_results();
            send_frame(pick_length(lim));
        end
    endtask

    task automatic write_limit(input logic [MAX_LEN_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        max_length_we <= 1'b1;
        max_length_wdata <= value;
        @(negedge clk);
        max_length_we <= 1'b0;
    endtask

    task automatic set_mix(input idle_mix_t mix);
        case (mix)
            MIX_SENDER:
            begin
                send_idle_pct = 77;
                stall_pct = 0;
            end
            MIX_RECEIVER:
            begin
                send_idle_pct = 0;
                stall_pct = 77;
            end
            MIX_BOTH:
            begin
                send_idle_pct = 17;
                stall_pct = 17;
            end
            default:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    initial
    begin
        stim_row_t tail_row;
        bit        negative_header;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_mix(MIX_NONE);
        foreach (LEAD_ROWS[i])
            put_byte(LEAD_ROWS[i]);
        run_frames(MAX_LEN_RESET);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limit(PHASE_LIMITS[p]);
            set_mix(PHASE_MIXES[p]);
            run_frames(PHASE_LIMITS[p]);
        end

        // A bad header shuts the stream down for good, so it comes last.
        set_mix(MIX_BOTH);
        negative_header = 1'($urandom_range(0, 1));
        for (int i = 0; i < LPD_HEADER_BYTES; i++)
        begin
            tail_row = '0;
            tail_row.typed = 1'b1;
            if (negative_header)
                tail_row.b = 8'hFF;
            else
                tail_row.b = (i == 1 || i == 3) ? 8'h01 : 8'h00;
            if (i == LPD_HEADER_BYTES - 1)
            begin
                tail_row.has = 1'b1;
                tail_row.r = '{KIND_ERROR, 8'h00, 1'b0};
            end
            put_byte(tail_row);
        end
        for (int i = 0; i < 3; i++)
        begin
            tail_row = '0;
            tail_row.typed = 1'b1;
            tail_row.b = 8'($urandom_range(0, 255));
            put_byte(tail_row);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d stream bytes under %0d length limits and four idle mixes.",
                 items_sent, NUM_PHASES + 1);
        $display("Checked %0d payload bytes, %0d empty messages and %0d length errors.",
                 payload_seen, empty_seen, error_seen);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
